@@ rtl/wnml_pkg.sv @@
// Shared types, constants and helpers of the weighted node min list.
package wnml_pkg;

  localparam int ENTRIES      = 64;
  localparam int NODE_ID_BITS = 16;

  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int COUNT_W     = $clog2(ENTRIES + 1);
  localparam int NODE_PORT_W = 16;
  localparam int WEIGHT_W    = 32;
  localparam int LEN_W       = 7;
  localparam int STORE_W     = (NODE_ID_BITS < NODE_PORT_W) ? NODE_ID_BITS : NODE_PORT_W;

  localparam logic signed [WEIGHT_W-1:0] W_MAX  = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] W_NONE = '1;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_QUERY  = 3'd2,
    OP_SET    = 3'd3,
    OP_MIN    = 3'd4,
    OP_COUNT  = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [STORE_W-1:0]         node;
    logic signed [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]           link;
  } entry_t;

  // Lowest set bit of the free mask.
  function automatic logic [IDX_W-1:0] lowest_free(input logic [ENTRIES-1:0] mask);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ rtl/wnml_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module wnml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/weighted_node_min_list.sv @@
// Weighted node min list: linked list of node ids with weights, held in one RAM.
//
// Input channel (in_valid/in_ready) takes one request: opcode, node id, weight.
// Result channel (out_valid/out_ready) returns exactly one result per request:
// found flag, node, weight, list length after the request, and status.
// Lookups walk the linked entries newest first, one RAM read per cycle with
// the read registered in the RAM, so their time is set by that port:
//   insert, count, clear, or an empty list: no walk, straight to the result;
//   remove, query, set weight: the walk stops at the newest match;
//   find min, or a lookup that misses: the walk covers the whole list.
// Requests are taken one at a time; in_ready is high only between requests.
// The next request is accepted the cycle after a result is loaded. The result
// sits in an output register, so the next request is accepted while a result
// still waits; a stalled receiver holds the block once a second result is
// ready. Reset empties the list (all slots free, length zero); RAM contents
// are left as they are and are never used before being written.
module weighted_node_min_list
  import wnml_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_opcode,
  input  logic [NODE_PORT_W-1:0]     in_node_id,
  input  logic signed [WEIGHT_W-1:0] in_weight_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_found,
  output logic [NODE_PORT_W-1:0]     out_node_out,
  output logic signed [WEIGHT_W-1:0] out_weight_out,
  output logic [LEN_W-1:0]           out_length,
  output logic [1:0]                 out_status
);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic [ENTRIES-1:0]         free_r, free_nxt;
  logic [IDX_W-1:0]           cur_r, cur_nxt;
  logic [IDX_W-1:0]           prev_r, prev_nxt;
  logic                       prev_valid_r, prev_valid_nxt;
  logic [STORE_W-1:0]         prev_node_r, prev_node_nxt;
  logic signed [WEIGHT_W-1:0] prev_weight_r, prev_weight_nxt;
  logic [COUNT_W-1:0]         steps_r, steps_nxt;
  op_t                        op_r, op_nxt;
  logic [STORE_W-1:0]         id_r, id_nxt;
  logic signed [WEIGHT_W-1:0] win_r, win_nxt;
  logic signed [WEIGHT_W-1:0] best_r, best_nxt;
  logic [STORE_W-1:0]         best_node_r, best_node_nxt;
  logic                       res_found_r, res_found_nxt;
  logic [STORE_W-1:0]         res_node_r, res_node_nxt;
  logic signed [WEIGHT_W-1:0] res_weight_r, res_weight_nxt;
  status_t                    res_status_r, res_status_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [NODE_PORT_W-1:0]     out_node_r, out_node_nxt;
  logic signed [WEIGHT_W-1:0] out_weight_r, out_weight_nxt;
  logic [LEN_W-1:0]           out_length_r, out_length_nxt;
  status_t                    out_status_r, out_status_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  entry_t                  ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                  rd_entry;

  logic             is_lookup;
  logic             walk_hit;
  logic             walk_last;
  logic             walk_done;
  logic             min_better;
  logic             any_free;
  logic [IDX_W-1:0] slot;
  logic             full;
  logic             out_free;

  wnml_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry   = ram_rdata;
  assign is_lookup  = (op_r == OP_REMOVE) || (op_r == OP_QUERY) || (op_r == OP_SET);
  assign walk_hit   = is_lookup && (rd_entry.node == id_r);
  assign walk_last  = (COUNT_W'(steps_r + COUNT_W'(1)) == count_r);
  assign walk_done  = walk_hit || walk_last;
  assign min_better = (rd_entry.weight > 0) && (rd_entry.weight < best_r);
  assign any_free   = |free_r;
  assign slot       = lowest_free(free_r);
  assign full       = (count_r >= COUNT_W'(ENTRIES)) || !any_free;
  assign out_free   = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if ((is_lookup || op_r == OP_MIN) && count_r != '0) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM access and handshake
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    ram_raddr = (state_r == S_WALK) ? rd_entry.link : head_r;
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = rd_entry;
    case (state_r)
      S_START: begin
        if (op_r == OP_INSERT && !full) begin
          ram_we    = 1'b1;
          ram_waddr = slot;
          ram_wdata = '{node: id_r, weight: W_NONE, link: head_r};
        end
      end
      S_WALK: begin
        if (walk_hit && op_r == OP_SET) begin
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          ram_wdata = '{node: rd_entry.node, weight: win_r, link: rd_entry.link};
        end else if (walk_hit && op_r == OP_REMOVE && prev_valid_r) begin
          // unlink: point the entry before the match past it
          ram_we    = 1'b1;
          ram_waddr = prev_r;
          ram_wdata = '{node: prev_node_r, weight: prev_weight_r, link: rd_entry.link};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Datapath
  always_comb begin
    head_nxt        = head_r;
    count_nxt       = count_r;
    free_nxt        = free_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    prev_valid_nxt  = prev_valid_r;
    prev_node_nxt   = prev_node_r;
    prev_weight_nxt = prev_weight_r;
    steps_nxt       = steps_r;
    op_nxt          = op_r;
    id_nxt          = id_r;
    win_nxt         = win_r;
    best_nxt        = best_r;
    best_node_nxt   = best_node_r;
    res_found_nxt   = res_found_r;
    res_node_nxt    = res_node_r;
    res_weight_nxt  = res_weight_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_found_nxt   = out_found_r;
    out_node_nxt    = out_node_r;
    out_weight_nxt  = out_weight_r;
    out_length_nxt  = out_length_r;
    out_status_nxt  = out_status_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = op_t'(in_opcode);
          id_nxt  = in_node_id[STORE_W-1:0];
          win_nxt = in_weight_in;
        end
      end
      S_START: begin
        res_found_nxt  = 1'b0;
        res_node_nxt   = '0;
        res_weight_nxt = W_NONE;
        res_status_nxt = ST_OK;
        cur_nxt        = head_r;
        prev_valid_nxt = 1'b0;
        steps_nxt      = '0;
        best_nxt       = W_MAX;
        best_node_nxt  = '0;
        case (op_r)
          OP_INSERT: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              free_nxt[slot] = 1'b0;
              head_nxt       = slot;
              count_nxt      = COUNT_W'(count_r + COUNT_W'(1));
            end
          end
          OP_REMOVE, OP_QUERY, OP_SET: begin
            if (count_r == '0) begin
              res_status_nxt = ST_NOT_FOUND;
            end
          end
          OP_CLEAR: begin
            head_nxt  = '0;
            count_nxt = '0;
            free_nxt  = '1;
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end
      S_WALK: begin
        if (walk_hit) begin
          res_found_nxt = 1'b1;
          case (op_r)
            OP_SET: begin
              res_weight_nxt = win_r;
            end
            OP_REMOVE: begin
              res_weight_nxt = rd_entry.weight;
              if (!prev_valid_r) begin
                head_nxt = rd_entry.link;
              end
              free_nxt[cur_r] = 1'b1;
              count_nxt       = COUNT_W'(count_r - COUNT_W'(1));
            end
            default: begin
              res_weight_nxt = rd_entry.weight;
            end
          endcase
        end else begin
          if (op_r == OP_MIN && min_better) begin
            best_nxt      = rd_entry.weight;
            best_node_nxt = rd_entry.node;
            res_found_nxt = 1'b1;
          end
          if (walk_last) begin
            if (op_r == OP_MIN) begin
              // fold in the last entry before reporting
              if (min_better) begin
                res_weight_nxt = rd_entry.weight;
                res_node_nxt   = rd_entry.node;
              end else if (res_found_r) begin
                res_weight_nxt = best_r;
                res_node_nxt   = best_node_r;
              end
            end else begin
              res_status_nxt = ST_NOT_FOUND;
            end
          end else begin
            // advance to the next linked entry
            prev_nxt        = cur_r;
            prev_valid_nxt  = 1'b1;
            prev_node_nxt   = rd_entry.node;
            prev_weight_nxt = rd_entry.weight;
            cur_nxt         = rd_entry.link;
            steps_nxt       = COUNT_W'(steps_r + COUNT_W'(1));
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_node_nxt   = NODE_PORT_W'(res_node_r);
          out_weight_nxt = res_weight_r;
          out_length_nxt = LEN_W'(count_r);
          out_status_nxt = res_status_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      free_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r         <= cur_nxt;
    prev_r        <= prev_nxt;
    prev_valid_r  <= prev_valid_nxt;
    prev_node_r   <= prev_node_nxt;
    prev_weight_r <= prev_weight_nxt;
    steps_r       <= steps_nxt;
    op_r          <= op_nxt;
    id_r          <= id_nxt;
    win_r         <= win_nxt;
    best_r        <= best_nxt;
    best_node_r   <= best_node_nxt;
    res_found_r   <= res_found_nxt;
    res_node_r    <= res_node_nxt;
    res_weight_r  <= res_weight_nxt;
    res_status_r  <= res_status_nxt;
    out_found_r   <= out_found_nxt;
    out_node_r    <= out_node_nxt;
    out_weight_r  <= out_weight_nxt;
    out_length_r  <= out_length_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_node_out   = out_node_r;
  assign out_weight_out = out_weight_r;
  assign out_length     = out_length_r;
  assign out_status     = out_status_r;

endmodule

@@ bench/tb_weighted_node_min_list.sv @@
// Testbench for the weighted node min list: directed and random requests against a list model.
`timescale 1ns / 100ps

module tb_weighted_node_min_list;
  import wnml_pkg::*;

  localparam logic [2:0] OP_NOP = 3'd7;
  localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 2000;

  typedef struct {
    logic                       found;
    logic [NODE_PORT_W-1:0]     node;
    logic signed [WEIGHT_W-1:0] weight;
    logic [LEN_W-1:0]           length;
    status_t                    status;
  } list_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [2:0]                 in_opcode = OP_COUNT;
  logic [NODE_PORT_W-1:0]     in_node_id = '0;
  logic signed [WEIGHT_W-1:0] in_weight_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_found;
  logic [NODE_PORT_W-1:0]     out_node_out;
  logic signed [WEIGHT_W-1:0] out_weight_out;
  logic [LEN_W-1:0]           out_length;
  logic [1:0]                 out_status;

  weighted_node_min_list dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_node_id     (in_node_id),
    .in_weight_in   (in_weight_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_node_out   (out_node_out),
    .out_weight_out (out_weight_out),
    .out_length     (out_length),
    .out_status     (out_status)
  );

  // List model state
  logic [STORE_W-1:0]         lst_node   [ENTRIES];
  logic signed [WEIGHT_W-1:0] lst_weight [ENTRIES];
  logic [IDX_W-1:0]           lst_link   [ENTRIES];
  bit                         lst_free   [ENTRIES];
  logic [IDX_W-1:0]           lst_head;
  int                         lst_len;

  list_result_t results_due[$];
  int  errors = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  hold_request = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic [NODE_PORT_W-1:0] id_in,
                                                 input logic signed [WEIGHT_W-1:0] w);
    list_result_t               r;
    logic [STORE_W-1:0]         id;
    logic [IDX_W-1:0]           cur, prev, hit, slot;
    logic signed [WEIGHT_W-1:0] best;
    bit                         has_prev, matched, got_slot;
    int                         i;
    r.found  = 1'b0;
    r.node   = '0;
    r.weight = W_NONE;
    r.status = ST_OK;
    id = id_in[STORE_W-1:0];
    prev = '0;
    hit = '0;
    slot = '0;
    case (op)
      OP_INSERT: begin
        got_slot = 1'b0;
        for (i = ENTRIES - 1; i >= 0; i--) begin
          if (lst_free[i]) begin
            slot = IDX_W'(i);
            got_slot = 1'b1;
          end
        end
        if (lst_len >= ENTRIES || !got_slot) begin
          r.status = ST_FULL;
        end else begin
          lst_free[slot]   = 1'b0;
          lst_node[slot]   = id;
          lst_weight[slot] = W_NONE;
          lst_link[slot]   = lst_head;
          lst_head         = slot;
          lst_len++;
        end
      end
      OP_REMOVE, OP_QUERY, OP_SET: begin
        matched = 1'b0;
        has_prev = 1'b0;
        cur = lst_head;
        for (i = 0; i < lst_len && !matched; i++) begin
          if (lst_node[cur] == id) begin
            matched = 1'b1;
            hit = cur;
          end else begin
            prev = cur;
            has_prev = 1'b1;
            cur = lst_link[cur];
          end
        end
        if (!matched) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          case (op)
            OP_REMOVE: begin
              r.weight = lst_weight[hit];
              if (!has_prev) lst_head = lst_link[hit];
              else lst_link[prev] = lst_link[hit];
              lst_free[hit] = 1'b1;
              lst_len--;
            end
            OP_QUERY: r.weight = lst_weight[hit];
            default: begin
              lst_weight[hit] = w;
              r.weight = w;
            end
          endcase
        end
      end
      OP_MIN: begin
        best = W_MAX;
        cur = lst_head;
        for (i = 0; i < lst_len; i++) begin
          // strictly less keeps the first of equal weights in list order
          if (lst_weight[cur] < best && lst_weight[cur] > 0) begin
            best = lst_weight[cur];
            r.node = NODE_PORT_W'(lst_node[cur]);
            r.found = 1'b1;
          end
          cur = lst_link[cur];
        end
        if (r.found) r.weight = best;
      end
      OP_CLEAR: begin
        lst_head = '0;
        lst_len = 0;
        for (i = 0; i < ENTRIES; i++) lst_free[i] = 1'b1;
      end
      default: ; // count and the spare opcode change nothing
    endcase
    r.length = LEN_W'(lst_len);
    return r;
  endfunction

  function automatic logic [NODE_PORT_W-1:0] live_node_at(input int pos);
    logic [IDX_W-1:0] cur;
    cur = lst_head;
    repeat (pos) cur = lst_link[cur];
    return NODE_PORT_W'(lst_node[cur]);
  endfunction

  function automatic logic [NODE_PORT_W-1:0] pick_node_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && lst_len > 0) return live_node_at($urandom_range(0, lst_len - 1));
    if (r < 80) return NODE_PORT_W'($urandom_range(0, 15));
    return NODE_PORT_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return W_MAX;
      1: return W_MAX - 1;
      2: return 1;
      3: return 0;
      4: return W_NONE;
      5: return W_MIN;
      6, 7: return WEIGHT_W'($urandom_range(1, 1000));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // Send one request in bursts with random gaps; predict it once accepted.
  task automatic issue_request(input logic [2:0] op, input logic [NODE_PORT_W-1:0] id,
                               input logic signed [WEIGHT_W-1:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_node_id   <= id;
    in_weight_in <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    results_due.push_back(apply_list_op(op, id, w));
  endtask

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result found=%0b node=%0d weight=%0d length=%0d status=%0d",
                 $time, out_found, out_node_out, out_weight_out, out_length, out_status);
        errors++;
      end else begin
        exp_r = results_due.pop_front();
        check_field("found", 64'(exp_r.found), 64'(out_found));
        check_field("node_out", 64'(exp_r.node), 64'(out_node_out));
        check_field("weight_out", 64'(exp_r.weight), 64'(out_weight_out));
        check_field("length", 64'(exp_r.length), 64'(out_length));
        check_field("status", 64'(exp_r.status), 64'(out_status));
      end
    end
  end

  // Receiver: alternate ready and stall runs, or hold off for a long stretch on demand.
  initial begin : receiver
    int  hold_left;
    int  pat_left;
    bit  pat_ready;
    hold_left = 0;
    pat_left = 0;
    pat_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_ready = !pat_ready;
          if (pat_ready) begin
            pat_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 12);
          end else begin
            pat_left = $urandom_range(1, 7);
          end
        end
        pat_left--;
        out_ready <= pat_ready;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic test_empty_and_basics();
    issue_request(OP_COUNT, '0, '0);
    issue_request(OP_MIN, '0, '0);
    issue_request(OP_QUERY, '0, '0);
    issue_request(OP_REMOVE, 16'hFFFF, '0);
    issue_request(OP_SET, 16'h0001, 32'sd5);
    issue_request(OP_INSERT, 16'hFFFF, W_MAX);
    issue_request(OP_INSERT, 16'h0000, '0);
    issue_request(OP_INSERT, 16'hFFFF, '0);
    issue_request(OP_QUERY, 16'hFFFF, '0);
    issue_request(OP_SET, 16'hFFFF, W_MAX);
    // the largest weight never wins a min search
    issue_request(OP_MIN, '0, '0);
    issue_request(OP_SET, 16'h0000, 32'sd1);
    issue_request(OP_MIN, '0, '0);
    issue_request(OP_SET, 16'hFFFF, W_MIN);
    issue_request(OP_INSERT, 16'h1234, '0);
    issue_request(OP_SET, 16'h1234, 32'sd1);
    // tie on weight one: the newer entry comes first in list order
    issue_request(OP_MIN, '0, '0);
    issue_request(OP_REMOVE, 16'hFFFF, '0);
    issue_request(OP_QUERY, 16'hFFFF, '0);
    issue_request(OP_REMOVE, 16'h0000, '0);
    issue_request(OP_NOP, 16'hA5A5, 32'sh5A5A5A5A);
    issue_request(OP_CLEAR, '0, '0);
    issue_request(OP_COUNT, '0, '0);
    issue_request(OP_MIN, '0, '0);
  endtask

  task automatic test_fill_to_capacity();
    int i;
    issue_request(OP_CLEAR, '0, '0);
    for (i = 0; i < ENTRIES; i++) issue_request(OP_INSERT, NODE_PORT_W'(16'h0100 + i), '0);
    for (i = 0; i < ENTRIES; i++) begin
      issue_request(OP_SET, NODE_PORT_W'(16'h0100 + i), WEIGHT_W'($urandom_range(2, 5000)));
    end
    issue_request(OP_INSERT, 16'hBEEF, '0);
    issue_request(OP_MIN, '0, '0);
    // oldest entry sits at the tail, absent node walks the whole list
    issue_request(OP_QUERY, 16'h0100, '0);
    issue_request(OP_QUERY, 16'hDEAD, '0);
    issue_request(OP_REMOVE, 16'h0120, '0);
    issue_request(OP_INSERT, 16'h2000, '0);
    issue_request(OP_SET, 16'h2000, 32'sd1);
    issue_request(OP_MIN, '0, '0);
    issue_request(OP_INSERT, 16'h2001, '0);
    issue_request(OP_REMOVE, 16'h2000, '0);
    issue_request(OP_REMOVE, 16'h0100, '0);
    issue_request(OP_MIN, '0, '0);
    issue_request(OP_COUNT, '0, '0);
  endtask

  task automatic test_output_backpressure();
    int i;
    hold_request = 1'b1;
    for (i = 0; i < 8; i++) begin
      issue_request((i % 2 == 0) ? OP_INSERT : OP_QUERY, pick_node_id(), pick_weight());
    end
  endtask

  task automatic test_random_traffic();
    int         n, pick, insert_pct;
    logic [2:0] op;
    insert_pct = 30;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // vary the insert share so the list grows toward full and shrinks again
      if (n % 150 == 0) insert_pct = $urandom_range(15, 60);
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) begin
        op = OP_INSERT;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 18)      op = OP_REMOVE;
        else if (pick < 36) op = OP_QUERY;
        else if (pick < 68) op = OP_SET;
        else if (pick < 88) op = OP_MIN;
        else if (pick < 98) op = OP_COUNT;
        else if (pick < 99) op = OP_CLEAR;
        else                op = OP_NOP;
      end
      issue_request(op, pick_node_id(), pick_weight());
    end
  endtask

  initial begin : main
    int i;
    lst_head = '0;
    lst_len = 0;
    for (i = 0; i < ENTRIES; i++) lst_free[i] = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_basics();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
